// ===== sv/fixed_point_alu_q24_8_defines.svh =====
// assertion macros for the q24.8 alu checker
// clocked on clk_i, disabled while rst_ni is low
`ifndef FIXED_POINT_ALU_Q24_8_DEFINES_SVH
`define FIXED_POINT_ALU_Q24_8_DEFINES_SVH

// same-cycle implication
`define FPA_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("fpa check failed");

// next-cycle implication
`define FPA_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("fpa check failed");

`endif

// ===== sv/fpa_pkg.sv =====
// types and constants of the q24.8 fixed-point alu
// no dependencies
package fpa_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned NumerW = 48;

  typedef enum logic [3:0] {
    MODE_ADD  = 4'd0,
    MODE_SUB  = 4'd1,
    MODE_MUL  = 4'd2,
    MODE_DIV  = 4'd3,
    MODE_NEG  = 4'd4,
    MODE_MIN  = 4'd5,
    MODE_MAX  = 4'd6,
    MODE_INC  = 4'd7,
    MODE_DEC  = 4'd8,
    MODE_TOINT = 4'd9
  } mode_e;

  typedef struct packed {
    logic [3:0]         mode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } fpa_in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               overflow;
    logic               a_less;
    logic               a_equal;
    logic               a_greater;
  } fpa_out_t;

  // item as it moves along the divider row
  typedef struct packed {
    logic [3:0]        mode;
    logic [DataW-1:0]  simple_val;
    logic              simple_ovf;
    logic              less;
    logic              equal;
    logic              greater;
    logic              neg;
    logic [63:0]       prod;
    logic [DataW-1:0]  den;
    logic [NumerW-1:0] numer;
    logic [DataW-1:0]  rem;
    logic [NumerW-1:0] quo;
  } fpa_cell_t;

endpackage

// ===== sv/fixed_point_alu_q24_8.sv =====
// signed q24.8 fixed-point alu: front stage, a row of 32+FRACTION_BITS
// restoring-division cells, then a rounding and output stage
// every mode passes through every stage; one item per cycle unless the row stalls
// the row stalls as a whole only while the output item waits
// reset clears the valid bits of all stages; payload is not reset
module fixed_point_alu_q24_8 #(
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  fpa_pkg::fpa_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output fpa_pkg::fpa_out_t out_data_o
);
  import fpa_pkg::*;

  localparam int unsigned NCells = 32 + FRACTION_BITS;

  logic      adv;
  logic      v [NCells+1];
  fpa_cell_t d [NCells+1];

  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  fpa_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
    .clk_i, .rst_ni, .adv_i(adv),
    .valid_i(in_valid_i), .data_i(in_data_i),
    .valid_o(v[0]), .data_o(d[0])
  );

  for (genvar i = 0; i < NCells; i++) begin : g_cell
    fpa_div_cell u_cell (
      .clk_i, .rst_ni, .adv_i(adv),
      .valid_i(v[i]), .data_i(d[i]),
      .valid_o(v[i+1]), .data_o(d[i+1])
    );
  end

  fpa_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk_i, .rst_ni, .adv_i(adv),
    .valid_i(v[NCells]), .data_i(d[NCells]),
    .valid_o(out_valid_o), .data_o(out_data_o)
  );
endmodule

// ===== sv/fpa_front.sv =====
// first stage: simple operations, magnitudes, product and divider setup
// depends on fpa_pkg
module fpa_front #(
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic              valid_i,
  input  fpa_pkg::fpa_in_t  data_i,
  output logic              valid_o,
  output fpa_pkg::fpa_cell_t data_o
);
  import fpa_pkg::*;

  logic               valid_q;
  fpa_cell_t          data_q, data_d;
  logic signed [31:0] a, b;
  logic [32:0]        sum, diff;
  logic [31:0]        mag_a, mag_b;

  assign a     = data_i.operand_a;
  assign b     = data_i.operand_b;
  assign mag_a = a[31] ? 32'(-a) : 32'(a);
  assign mag_b = b[31] ? 32'(-b) : 32'(b);
  assign sum   = {a[31], a} + {b[31], b};
  assign diff  = {a[31], a} - {b[31], b};

  always_comb begin
    data_d            = '0;
    data_d.mode       = data_i.mode;
    data_d.less       = a < b;
    data_d.equal      = a == b;
    data_d.greater    = a > b;
    data_d.neg        = a[31] ^ b[31];
    data_d.prod       = 64'(mag_a) * 64'(mag_b);
    data_d.den        = mag_b;
    data_d.numer      = {mag_a, 16'd0};
    case (data_i.mode)
      MODE_ADD: begin
        data_d.simple_ovf = sum[32] ^ sum[31];
        data_d.simple_val = data_d.simple_ovf ? '0 : sum[31:0];
      end
      MODE_SUB: begin
        data_d.simple_ovf = diff[32] ^ diff[31];
        data_d.simple_val = data_d.simple_ovf ? '0 : diff[31:0];
      end
      MODE_NEG: begin
        data_d.simple_ovf = a == 32'sh8000_0000;
        data_d.simple_val = data_d.simple_ovf ? '0 : 32'(-a);
      end
      MODE_MIN:   data_d.simple_val = (a < b) ? a : b;
      MODE_MAX:   data_d.simple_val = (a > b) ? a : b;
      MODE_INC:   data_d.simple_val = a + 32'sd1;
      MODE_DEC:   data_d.simple_val = a - 32'sd1;
      MODE_TOINT: data_d.simple_val = a >>> FRACTION_BITS;
      default:    data_d.simple_val = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

// ===== sv/fpa_div_cell.sv =====
// one restoring-division cell: one quotient bit per item per cycle while adv_i is high
// depends on fpa_pkg
module fpa_div_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               valid_i,
  input  fpa_pkg::fpa_cell_t data_i,
  output logic               valid_o,
  output fpa_pkg::fpa_cell_t data_o
);
  import fpa_pkg::*;

  logic      valid_q;
  fpa_cell_t data_q, data_d;
  logic [32:0] trial, sub;
  logic        ge;

  assign trial = {data_i.rem, data_i.numer[NumerW-1]};
  assign sub   = trial - {1'b0, data_i.den};
  assign ge    = trial >= {1'b0, data_i.den};

  always_comb begin
    data_d       = data_i;
    data_d.rem   = ge ? sub[31:0] : trial[31:0];
    data_d.quo   = {data_i.quo[NumerW-2:0], ge};
    data_d.numer = {data_i.numer[NumerW-2:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

// ===== sv/fpa_back.sv =====
// last stage: rounding of multiply and divide, range check, output register
// depends on fpa_pkg
module fpa_back #(
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               valid_i,
  input  fpa_pkg::fpa_cell_t data_i,
  output logic               valid_o,
  output fpa_pkg::fpa_out_t  data_o
);
  import fpa_pkg::*;

  localparam logic [63:0] Half = (FRACTION_BITS > 0) ? (64'd1 << (FRACTION_BITS - 1)) : 64'd0;

  logic        valid_q;
  fpa_out_t    data_q, data_d;
  logic [63:0] m_mul, mag;
  logic [NumerW-1:0] m_div;
  logic        neg_eff, too_big;

  assign m_mul   = (data_i.prod + Half) >> FRACTION_BITS;
  // round half up on the remainder
  assign m_div   = data_i.quo + NumerW'({data_i.rem, 1'b0} >= {1'b0, data_i.den});
  assign mag     = (data_i.mode == MODE_MUL) ? m_mul : 64'(m_div);
  assign neg_eff = data_i.neg && (mag != 64'd0);
  assign too_big = neg_eff ? (mag > 64'h8000_0000) : (mag > 64'h7fff_ffff);

  always_comb begin
    data_d           = '0;
    data_d.a_less    = data_i.less;
    data_d.a_equal   = data_i.equal;
    data_d.a_greater = data_i.greater;
    case (data_i.mode)
      MODE_MUL, MODE_DIV: begin
        if (too_big || (data_i.mode == MODE_DIV && data_i.den == '0)) begin
          data_d.overflow = 1'b1;
        end else begin
          data_d.result_value = neg_eff ? 32'(-mag) : mag[31:0];
        end
      end
      default: begin
        data_d.result_value = data_i.simple_val;
        data_d.overflow     = data_i.simple_ovf;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

// ===== sv/fpa_checker.sv =====
// port-level checks on the q24.8 alu, bound to the top level
// depends on fpa_pkg and fixed_point_alu_q24_8_defines.svh
`include "fixed_point_alu_q24_8_defines.svh"
module fpa_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input fpa_pkg::fpa_out_t out_data_o
);
  import fpa_pkg::*;

  `FPA_ASSERT_NOW(a_ovf_zero, out_valid_o && out_data_o.overflow, out_data_o.result_value == '0)
  `FPA_ASSERT_NOW(a_cmp_onehot, out_valid_o, $onehot({out_data_o.a_less, out_data_o.a_equal, out_data_o.a_greater}))
  `FPA_ASSERT_NOW(a_ready_free, !out_valid_o, in_ready_o)
  `FPA_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))
endmodule

bind fixed_point_alu_q24_8 fpa_checker u_fpa_checker (
  .clk_i, .rst_ni, .in_ready_o, .out_valid_o, .out_ready_i, .out_data_o
);
